// ===== hw/rtl/mia_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, types and index tables for the 3x3 adjugate inverse core.
package mia_pkg;

    localparam int N_ENT  = 9;
    localparam int N_TERM = 3;
    localparam int WORD_W = 32;
    localparam int PROD_W = 64;
    localparam int ADJ_W  = 65;
    localparam int AMAG_W = 63;
    localparam int TMAG_W = 95;
    localparam int DET_W  = 98;
    localparam int DMAG_W = 96;
    localparam int WIDE_W = 128;
    localparam int Q_W    = 32;

    localparam logic [Q_W:0] LIM_POS = {2'b00, {(Q_W-1){1'b1}}};
    localparam logic [Q_W:0] LIM_NEG = {2'b01, {(Q_W-1){1'b0}}};

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [3:0] idx_t;

    // cofactor i = a[p]*a[q] - a[r]*a[s], row-major adjugate
    localparam idx_t ADJ_IDX [N_ENT][4] = '{
        '{4'd4, 4'd8, 4'd7, 4'd5},
        '{4'd7, 4'd2, 4'd8, 4'd1},
        '{4'd5, 4'd1, 4'd4, 4'd2},
        '{4'd6, 4'd5, 4'd8, 4'd3},
        '{4'd8, 4'd0, 4'd6, 4'd2},
        '{4'd3, 4'd2, 4'd5, 4'd0},
        '{4'd7, 4'd3, 4'd6, 4'd4},
        '{4'd6, 4'd1, 4'd7, 4'd0},
        '{4'd4, 4'd0, 4'd3, 4'd1}
    };

    // column 1 expansion: entries paired with cofactors 0..2
    localparam idx_t DET_IDX [N_TERM] = '{4'd0, 4'd3, 4'd6};

    typedef struct packed {
        logic [N_ENT-1:0][WIDE_W-1:0] rem;
        logic [N_ENT-1:0][Q_W-1:0]    quo;
        logic [N_ENT-1:0]             ovf;
        logic [N_ENT-1:0]             neg;
        logic [DMAG_W-1:0]            dmag;
        logic                         dneg;
        logic                         dzero;
        logic [DMAG_W:0]              detr;
    } div_item_t;

endpackage

// ===== hw/rtl/mat3_inverse_adjugate_core.sv =====
`timescale 1ns / 1ps
// 3x3 matrix inverse by adjugate and pipelined restoring division.
//
//  channel   ports                          handshake
//  ------    -----------------------------  ---------------------------
//  in        a_r1c1 .. a_r3c3               start & !busy
//  out       inv_r1c1 .. inv_r3c3,          done, one cycle per item
//            det_value, singular
//
//  One item is taken every cycle; busy stays low.
//  The pipeline has 8 front stages (products, cofactors, determinant),
//  a division setup stage, 32 division stages of one quotient bit each,
//  then rounding and output stages.
//  Reset clears only the valid chain; data registers are not reset.
//  The receiver cannot stall, so nothing in the pipe ever waits.
module mat3_inverse_adjugate_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  mia_pkg::word_t  a_r1c1,
    input  mia_pkg::word_t  a_r1c2,
    input  mia_pkg::word_t  a_r1c3,
    input  mia_pkg::word_t  a_r2c1,
    input  mia_pkg::word_t  a_r2c2,
    input  mia_pkg::word_t  a_r2c3,
    input  mia_pkg::word_t  a_r3c1,
    input  mia_pkg::word_t  a_r3c2,
    input  mia_pkg::word_t  a_r3c3,
    output logic            done,
    output mia_pkg::word_t  inv_r1c1,
    output mia_pkg::word_t  inv_r1c2,
    output mia_pkg::word_t  inv_r1c3,
    output mia_pkg::word_t  inv_r2c1,
    output mia_pkg::word_t  inv_r2c2,
    output mia_pkg::word_t  inv_r2c3,
    output mia_pkg::word_t  inv_r3c1,
    output mia_pkg::word_t  inv_r3c2,
    output mia_pkg::word_t  inv_r3c3,
    output mia_pkg::word_t  det_value,
    output logic            singular
);

    import mia_pkg::*;

    localparam int SH      = 2 * FRAC_BITS;
    localparam int FRONT_N = 8;

    word_t a_in [N_ENT];

    logic [FRONT_N-1:0] fv_reg;
    logic [Q_W:0]       dv_reg;
    logic               rv_reg;
    logic               done_reg;

    word_t                    a0_reg  [N_ENT];
    logic signed [PROD_W-1:0] p1_reg  [N_ENT][2];
    word_t                    a1_reg  [N_TERM];
    logic signed [ADJ_W-1:0]  adj2_reg[N_ENT];
    word_t                    a2_reg  [N_TERM];
    logic [AMAG_W-1:0]        am3_reg [N_ENT];
    logic [N_ENT-1:0]         sn3_reg;
    logic [WORD_W-1:0]        aa3_reg [N_TERM];
    logic [N_TERM-1:0]        as3_reg;
    logic [PROD_W-1:0]        pl4_reg [N_TERM];
    logic [AMAG_W-1:0]        ph4_reg [N_TERM];
    logic [N_TERM-1:0]        tn4_reg;
    logic [AMAG_W-1:0]        am4_reg [N_ENT];
    logic [N_ENT-1:0]         sn4_reg;
    logic [DET_W-1:0]         t5_reg  [N_TERM];
    logic [N_TERM-1:0]        tn5_reg;
    logic [AMAG_W-1:0]        am5_reg [N_ENT];
    logic [N_ENT-1:0]         sn5_reg;
    logic signed [DET_W-1:0]  det6_reg;
    logic [AMAG_W-1:0]        am6_reg [N_ENT];
    logic [N_ENT-1:0]         sn6_reg;
    logic [DMAG_W-1:0]        dmag7_reg;
    logic                     dneg7_reg;
    logic                     dzero7_reg;
    logic [AMAG_W-1:0]        am7_reg [N_ENT];
    logic [N_ENT-1:0]         sn7_reg;

    div_item_t div_reg  [Q_W+1];
    div_item_t div_next [Q_W+1];

    logic [Q_W:0]      q_reg [N_ENT];
    logic [N_ENT-1:0]  rovf_reg;
    logic [N_ENT-1:0]  rneg_reg;
    logic              rdneg_reg;
    logic              rdzero_reg;
    logic [DMAG_W:0]   rdetr_reg;

    word_t inv_reg [N_ENT];
    word_t detv_reg;
    logic  sing_reg;

    assign a_in[0] = a_r1c1;
    assign a_in[1] = a_r1c2;
    assign a_in[2] = a_r1c3;
    assign a_in[3] = a_r2c1;
    assign a_in[4] = a_r2c2;
    assign a_in[5] = a_r2c3;
    assign a_in[6] = a_r3c1;
    assign a_in[7] = a_r3c2;
    assign a_in[8] = a_r3c3;

    assign busy = 1'b0;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg   <= '0;
            dv_reg   <= '0;
            rv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            fv_reg   <= {fv_reg[FRONT_N-2:0], start & ~busy};
            dv_reg   <= {dv_reg[Q_W-1:0], fv_reg[FRONT_N-1]};
            rv_reg   <= dv_reg[Q_W];
            done_reg <= rv_reg;
        end
    end

    // front stages: products, cofactors, magnitudes, determinant
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N_ENT; i++)
        begin
            a0_reg[i]    <= a_in[i];
            p1_reg[i][0] <= a0_reg[ADJ_IDX[i][0]] * a0_reg[ADJ_IDX[i][1]];
            p1_reg[i][1] <= a0_reg[ADJ_IDX[i][2]] * a0_reg[ADJ_IDX[i][3]];
            adj2_reg[i]  <= ADJ_W'(p1_reg[i][0]) - ADJ_W'(p1_reg[i][1]);
            am3_reg[i]   <= adj2_reg[i][ADJ_W-1] ? AMAG_W'(-adj2_reg[i])
                                                 : AMAG_W'(adj2_reg[i]);
            sn3_reg[i]   <= adj2_reg[i][ADJ_W-1];
            am4_reg[i]   <= am3_reg[i];
            am5_reg[i]   <= am4_reg[i];
            am6_reg[i]   <= am5_reg[i];
            am7_reg[i]   <= am6_reg[i];
        end
        sn4_reg <= sn3_reg;
        sn5_reg <= sn4_reg;
        sn6_reg <= sn5_reg;
        sn7_reg <= sn6_reg;

        for (int t = 0; t < N_TERM; t++)
        begin
            a1_reg[t]  <= a0_reg[DET_IDX[t]];
            a2_reg[t]  <= a1_reg[t];
            aa3_reg[t] <= a2_reg[t][WORD_W-1] ? WORD_W'(-a2_reg[t]) : WORD_W'(a2_reg[t]);
            as3_reg[t] <= a2_reg[t][WORD_W-1];
            pl4_reg[t] <= PROD_W'(am3_reg[t][WORD_W-1:0]) * PROD_W'(aa3_reg[t]);
            ph4_reg[t] <= AMAG_W'(am3_reg[t][AMAG_W-1:WORD_W]) * AMAG_W'(aa3_reg[t]);
            tn4_reg[t] <= sn3_reg[t] ^ as3_reg[t];
            // one's complement here, the +1 is folded into the sum
            t5_reg[t]  <= tn4_reg[t]
                        ? ~DET_W'(TMAG_W'({ph4_reg[t], {WORD_W{1'b0}}}) + TMAG_W'(pl4_reg[t]))
                        :  DET_W'(TMAG_W'({ph4_reg[t], {WORD_W{1'b0}}}) + TMAG_W'(pl4_reg[t]));
        end
        tn5_reg <= tn4_reg;

        det6_reg   <= $signed(t5_reg[0] + t5_reg[1] + t5_reg[2]
                              + DET_W'($countones(tn5_reg)));
        dmag7_reg  <= det6_reg[DET_W-1] ? DMAG_W'(-det6_reg) : DMAG_W'(det6_reg);
        dneg7_reg  <= det6_reg[DET_W-1];
        dzero7_reg <= (det6_reg == '0);
    end

    // division setup: numerator, overflow test, rounded determinant
    always_comb
    begin
        div_next[0]       = '0;
        div_next[0].dmag  = dmag7_reg;
        div_next[0].dneg  = dneg7_reg;
        div_next[0].dzero = dzero7_reg;
        div_next[0].detr  = ({1'b0, dmag7_reg} + ((DMAG_W+1)'(1) << (SH-1))) >> SH;
        for (int e = 0; e < N_ENT; e++)
        begin
            div_next[0].rem[e] = WIDE_W'(am7_reg[e]) << SH;
            div_next[0].ovf[e] = (WIDE_W'(am7_reg[e]) << SH) >= {dmag7_reg, {Q_W{1'b0}}};
            div_next[0].neg[e] = sn7_reg[e] ^ dneg7_reg;
        end
    end

    // one quotient bit per stage
    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        localparam int K = Q_W - 1 - j;
        logic [WIDE_W-1:0] dsh;

        assign dsh = WIDE_W'(div_reg[j].dmag) << K;

        always_comb
        begin
            div_next[j+1] = div_reg[j];
            for (int e = 0; e < N_ENT; e++)
            begin
                if (div_reg[j].rem[e] >= dsh)
                begin
                    div_next[j+1].rem[e]    = div_reg[j].rem[e] - dsh;
                    div_next[j+1].quo[e][K] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= Q_W; j++)
        begin
            div_reg[j] <= div_next[j];
        end
    end

    // round to nearest, ties away from zero
    always_ff @(posedge clk)
    begin
        for (int e = 0; e < N_ENT; e++)
        begin
            q_reg[e] <= {1'b0, div_reg[Q_W].quo[e]}
                      + (Q_W+1)'({div_reg[Q_W].rem[e], 1'b0} >=
                                 {{(WIDE_W+1-DMAG_W){1'b0}}, div_reg[Q_W].dmag});
        end
        rovf_reg   <= div_reg[Q_W].ovf;
        rneg_reg   <= div_reg[Q_W].neg;
        rdneg_reg  <= div_reg[Q_W].dneg;
        rdzero_reg <= div_reg[Q_W].dzero;
        rdetr_reg  <= div_reg[Q_W].detr;
    end

    // saturate, apply sign, zero on singular
    always_ff @(posedge clk)
    begin
        logic [Q_W:0] lim;
        logic [Q_W:0] mag;
        for (int e = 0; e < N_ENT; e++)
        begin
            lim = rneg_reg[e] ? LIM_NEG : LIM_POS;
            mag = (rovf_reg[e] || (q_reg[e] > lim)) ? lim : q_reg[e];
            if (rdzero_reg)
            begin
                inv_reg[e] <= '0;
            end
            else
            begin
                inv_reg[e] <= rneg_reg[e] ? -word_t'(mag[Q_W-1:0]) : word_t'(mag[Q_W-1:0]);
            end
        end
        lim = rdneg_reg ? LIM_NEG : LIM_POS;
        mag = (rdetr_reg > (DMAG_W+1)'(lim)) ? lim : rdetr_reg[Q_W:0];
        if (rdzero_reg)
        begin
            detv_reg <= '0;
        end
        else
        begin
            detv_reg <= rdneg_reg ? -word_t'(mag[Q_W-1:0]) : word_t'(mag[Q_W-1:0]);
        end
        sing_reg <= rdzero_reg;
    end

    assign done      = done_reg;
    assign inv_r1c1  = inv_reg[0];
    assign inv_r1c2  = inv_reg[1];
    assign inv_r1c3  = inv_reg[2];
    assign inv_r2c1  = inv_reg[3];
    assign inv_r2c2  = inv_reg[4];
    assign inv_r2c3  = inv_reg[5];
    assign inv_r3c1  = inv_reg[6];
    assign inv_r3c2  = inv_reg[7];
    assign inv_r3c3  = inv_reg[8];
    assign det_value = detv_reg;
    assign singular  = sing_reg;

`ifndef SYNTHESIS
    a_latency_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##43 done)
        else $error("item did not come out after pipeline latency");

    a_latency_miss: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##43 !done)
        else $error("result strobe without a matching item");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (det_value == '0 && inv_r1c1 == '0 && inv_r2c2 == '0
                                && inv_r3c3 == '0 && inv_r1c3 == '0 && inv_r3c1 == '0))
        else $error("singular item with nonzero outputs");
`endif

endmodule

// ===== sim/tb_mat3_inverse_adjugate_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 adjugate matrix inverse core.
module tb_mat3_inverse_adjugate_core;
    import mia_pkg::*;

    localparam int FRAC     = 16;
    localparam int N_RAND   = 1530;
    localparam int DRAIN    = 60;
    localparam int LIMIT    = 200000;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] WMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WMIN = 32'h8000_0000;

    typedef struct packed {
        logic [8:0][31:0] ent;
    } mat_t;

    typedef struct packed {
        logic [8:0][31:0] inv;
        logic [31:0]      det;
        logic             sing;
    } inv_res_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    word_t  a [9] = '{default: '0};
    logic   done;
    word_t  inv [9];
    word_t  det_value;
    logic   singular;

    mat_t      pending_mats [$];
    inv_res_t  inverse_q [$];
    mat_t      cur_mat;
    int        n_taken = 0;
    int        n_total = 0;
    int        n_errors = 0;
    int        idle_pct = 0;
    longint    cycles = 0;

    always #5 clk = ~clk;

    mat3_inverse_adjugate_core #(.FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a_r1c1(a[0]), .a_r1c2(a[1]), .a_r1c3(a[2]),
        .a_r2c1(a[3]), .a_r2c2(a[4]), .a_r2c3(a[5]),
        .a_r3c1(a[6]), .a_r3c2(a[7]), .a_r3c3(a[8]),
        .done(done),
        .inv_r1c1(inv[0]), .inv_r1c2(inv[1]), .inv_r1c3(inv[2]),
        .inv_r2c1(inv[3]), .inv_r2c2(inv[4]), .inv_r2c3(inv[5]),
        .inv_r3c1(inv[6]), .inv_r3c2(inv[7]), .inv_r3c3(inv[8]),
        .det_value(det_value), .singular(singular)
    );

    // round to nearest, ties away from zero, saturate to 32 bits
    function automatic logic [31:0] round_sat(logic [255:0] num, logic [255:0] den, bit neg);
        logic [255:0] q;
        logic [255:0] lim;
        q = ((num << 1) + den) / (den << 1);
        lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
        if (q > lim)
            q = lim;
        return neg ? 32'(-q) : q[31:0];
    endfunction

    function automatic inv_res_t inverse_of(mat_t m);
        logic signed [127:0] e [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] d;
        logic [255:0] dmag;
        logic [255:0] cmag;
        inv_res_t r;
        for (int i = 0; i < 9; i++)
            e[i] = $signed(m.ent[8-i]);
        cof[0] = e[4] * e[8] - e[7] * e[5];
        cof[1] = e[7] * e[2] - e[8] * e[1];
        cof[2] = e[5] * e[1] - e[4] * e[2];
        cof[3] = e[6] * e[5] - e[8] * e[3];
        cof[4] = e[8] * e[0] - e[6] * e[2];
        cof[5] = e[3] * e[2] - e[5] * e[0];
        cof[6] = e[7] * e[3] - e[6] * e[4];
        cof[7] = e[6] * e[1] - e[7] * e[0];
        cof[8] = e[4] * e[0] - e[3] * e[1];
        d = e[0] * cof[0] + e[3] * cof[1] + e[6] * cof[2];
        r = '0;
        if (d == 0) begin
            r.sing = 1'b1;
            return r;
        end
        dmag = (d < 0) ? 256'(-d) : 256'(d);
        for (int i = 0; i < 9; i++) begin
            cmag = (cof[i] < 0) ? 256'(-cof[i]) : 256'(cof[i]);
            r.inv[8-i] = round_sat(cmag << (2 * FRAC), dmag, (cof[i] < 0) != (d < 0));
        end
        r.det = round_sat(dmag, 256'd1 << (2 * FRAC), d < 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task automatic add_mat(logic [31:0] m0, logic [31:0] m1, logic [31:0] m2,
                           logic [31:0] m3, logic [31:0] m4, logic [31:0] m5,
                           logic [31:0] m6, logic [31:0] m7, logic [31:0] m8);
        mat_t m;
        m.ent = {m0, m1, m2, m3, m4, m5, m6, m7, m8};
        pending_mats.push_back(m);
        n_total++;
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return ONE;
            2: return -ONE;
            3: return WMAX;
            4: return WMIN;
            default: return 32'(-1);
        endcase
    endfunction

    function automatic logic [31:0] pick_word(int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000);
            2: return 32'($signed($urandom_range(511)) - 256);
            default: return pick_extreme();
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                inverse_q.push_back(inverse_of(cur_mat));
                n_taken++;
            end
            if (!(start && busy)) begin
                if (n_taken < n_total / 4)
                    idle_pct = 0;
                else if (n_taken < n_total / 2)
                    idle_pct = 85;
                else if (n_taken < 3 * n_total / 4)
                    idle_pct = 16;
                else
                    idle_pct = ((n_taken / 50) % 2) ? 50 : 0;
                if (pending_mats.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_mat = pending_mats.pop_front();
                    start <= 1'b1;
                    for (int i = 0; i < 9; i++)
                        a[i] <= cur_mat.ent[8-i];
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (inverse_q.size() == 0) begin
                n_errors++;
                $display("unexpected result");
            end else begin
                inv_res_t w;
                w = inverse_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (inv[i] !== w.inv[8-i])
                        report_mismatch($sformatf("inv[%0d]", i), inv[i], w.inv[8-i]);
                if (det_value !== w.det)
                    report_mismatch("det_value", det_value, w.det);
                if (singular !== w.sing)
                    report_mismatch("singular", 32'(singular), 32'(w.sing));
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("** mat3_inverse_adjugate_core: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [31:0] r [9];
        int kind;
        bit flip;
        // directed
        add_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        add_mat(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_mat(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 5, 7, 9);
        add_mat(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX);
        add_mat(WMIN, 0, 0, 0, WMIN, 0, 0, 0, WMIN);
        add_mat(WMAX, 0, 0, 0, WMAX, 0, 0, 0, WMAX);
        add_mat(WMIN, WMAX, 0, WMAX, WMIN, WMAX, 0, WMAX, WMIN);
        add_mat(1, 0, 0, 0, 1, 0, 0, 0, 1);
        add_mat(-1, 0, 0, 0, 1, 0, 0, 0, 1);
        add_mat(1, 0, 0, 0, 1, 0, 0, 0, 32'hFFFF_FFFF);
        add_mat(2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE);
        add_mat(3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE);
        add_mat(0, ONE, 0, ONE, 0, 0, 0, 0, ONE);
        add_mat(ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE);
        add_mat(ONE / 2, 0, 0, 0, 4 * ONE, 0, 0, 0, -ONE);
        add_mat(32'h0000_8000, 0, 0, 0, 32'h0000_8000, 0, 0, 0, 32'h0000_8000);
        add_mat(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN);
        add_mat(WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMAX);
        add_mat(-1, -1, -1, -1, -1, -1, -1, -1, -1);
        add_mat(3, 0, 0, 0, 1, 0, 0, 0, 1);
        // random
        for (int n = 0; n < N_RAND; n++) begin
            kind = $urandom_range(4);
            for (int i = 0; i < 9; i++)
                r[i] = pick_word(kind == 4 ? $urandom_range(3) : kind);
            if ($urandom_range(9) == 0) begin
                // rank-deficient: copy or negate a row
                flip = ($urandom_range(1) == 1);
                for (int j = 0; j < 3; j++)
                    r[6 + j] = flip ? -r[j] : r[j];
            end
            add_mat(r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]);
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_mats.size() == 0 && n_taken == n_total && inverse_q.size() == 0);
        repeat (DRAIN) @(posedge clk);
        if (n_errors == 0 && inverse_q.size() == 0)
            $display("** mat3_inverse_adjugate_core: PASSED **");
        else
            $display("** mat3_inverse_adjugate_core: FAILED **");
        $finish;
    end

endmodule
